// ===== rtl/tas_pkg.sv =====
// Shared constants and the arc tangent table of the triangle angle solver.
package tas_pkg;

    // Internal precision of the cosine, sine and angle words (Q30).
    localparam int QBITS        = 30;
    localparam int DIV_STEPS    = 30;
    localparam int SQRT_STEPS   = 31;
    localparam int CORDIC_STEPS = 30;
    // Width of the signed CORDIC words; covers the gain and a turned start vector.
    localparam int ANG_BITS     = 34;
    // Register stages from the lane inputs to its radian result.
    localparam int LANE_LAT     = 2 + DIV_STEPS + 2 + SQRT_STEPS + 1 + CORDIC_STEPS + 1;
    // Further register stages from a radian value to its degree value.
    localparam int DEG_LAT      = 2;

    localparam logic [ANG_BITS-1:0] HALF_PI_Q30 = 34'd1686629713;
    // round(180/pi * 2^30), split into two halves for narrow multipliers.
    localparam logic [35:0] DEG_PER_RAD = 36'd61520874802;
    localparam int          KSPLIT      = 18;

    // atan(2^-idx) in Q30; from step ten on it equals 2^(30-idx).
    function automatic logic [31:0] atan_q30(input logic [4:0] idx);
        logic [31:0] val;
        case (idx)
            5'd0:    val = 32'd843314857;
            5'd1:    val = 32'd497837829;
            5'd2:    val = 32'd263043837;
            5'd3:    val = 32'd133525159;
            5'd4:    val = 32'd67021687;
            5'd5:    val = 32'd33543516;
            5'd6:    val = 32'd16775851;
            5'd7:    val = 32'd8388437;
            5'd8:    val = 32'd4194283;
            5'd9:    val = 32'd2097149;
            default: val = 32'd1 << (5'd30 - idx);
        endcase
        return val;
    endfunction

endpackage

// ===== rtl/tas_angle.sv =====
// One angle lane: law of cosines, restoring divider, square root and CORDIC arc tangent.
module tas_angle #(
    parameter int SIDE_BITS = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [SIDE_BITS-1:0] i_opp,
    input  logic [SIDE_BITS-1:0] i_s1,
    input  logic [SIDE_BITS-1:0] i_s2,
    output logic [FRAC_BITS+1:0] o_rad,
    output logic [FRAC_BITS+7:0] o_deg
);

    localparam int QB   = tas_pkg::QBITS;
    localparam int ND   = tas_pkg::DIV_STEPS;
    localparam int NS   = tas_pkg::SQRT_STEPS;
    localparam int NC   = tas_pkg::CORDIC_STEPS;
    localparam int AW   = tas_pkg::ANG_BITS;
    localparam int KS   = tas_pkg::KSPLIT;
    localparam int PW   = 2 * SIDE_BITS;
    localparam int NW   = PW + 1;
    localparam int RW   = PW + 2;
    localparam int CW   = QB + 1;
    localparam int VW   = 2 * QB + 2;
    localparam int RADW = FRAC_BITS + 2;
    localparam int DEGW = FRAC_BITS + 8;
    localparam int SH   = QB - FRAC_BITS;
    localparam int PRW  = RADW + KS;
    localparam int TW   = RADW + 2 * KS + 1;

    localparam logic [VW-1:0] ONE_Q60 = VW'(1) << (2 * QB);
    localparam logic [AW-1:0] RND_RAD = AW'(1) << (SH - 1);
    localparam logic [TW-1:0] RND_DEG = TW'(1) << (QB - 1);

    // squares and cross product
    logic [PW-1:0] r_sq1, r_sq2, r_sqo, r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq1  <= i_s1 * i_s1;
            r_sq2  <= i_s2 * i_s2;
            r_sqo  <= i_opp * i_opp;
            r_prod <= i_s1 * i_s2;
        end
    end

    // numerator magnitude, its sign and the denominator; then one quotient bit a stage
    logic [NW-1:0] psum, qsq;
    logic [RW-1:0] r_drem [0:ND];
    logic [NW-1:0] r_dden [0:ND];
    logic [CW-1:0] r_dq   [0:ND];
    logic          r_dneg [0:ND];

    assign psum = {1'b0, r_sq1} + {1'b0, r_sq2};
    assign qsq  = {1'b0, r_sqo};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dneg[0] <= psum < qsq;
            r_drem[0] <= (psum < qsq) ? {1'b0, qsq - psum} : {1'b0, psum - qsq};
            r_dden[0] <= {r_prod, 1'b0};
            r_dq[0]   <= '0;
        end
    end

    for (genvar k = 0; k < ND; k++) begin : g_div
        logic [RW-1:0] shifted;
        logic          take;
        assign shifted = {r_drem[k][RW-2:0], 1'b0};
        assign take    = shifted >= {1'b0, r_dden[k]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_drem[k+1] <= take ? shifted - {1'b0, r_dden[k]} : shifted;
                r_dden[k+1] <= r_dden[k];
                r_dq[k+1]   <= {r_dq[k][CW-2:0], take};
                r_dneg[k+1] <= r_dneg[k];
            end
        end
    end

    // cosine squared, then the radicand of the sine
    logic [VW-1:0] r_csq;
    logic [CW-1:0] r_cq1;
    logic          r_neg1;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_csq  <= r_dq[ND] * r_dq[ND];
            r_cq1  <= r_dq[ND];
            r_neg1 <= r_dneg[ND];
        end
    end

    logic [VW-1:0] r_sv   [0:NS];
    logic [VW-1:0] r_sr   [0:NS];
    logic [CW-1:0] r_scq  [0:NS];
    logic          r_sneg [0:NS];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sv[0]   <= ONE_Q60 - r_csq;
            r_sr[0]   <= '0;
            r_scq[0]  <= r_cq1;
            r_sneg[0] <= r_neg1;
        end
    end

    // digit-by-digit square root, one result bit a stage
    for (genvar j = 0; j < NS; j++) begin : g_sqrt
        localparam logic [VW-1:0] BITV = VW'(1) << (2 * QB - 2 * j);
        logic [VW-1:0] trial;
        logic          take;
        assign trial = r_sr[j] + BITV;
        assign take  = r_sv[j] >= trial;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sv[j+1]   <= take ? r_sv[j] - trial : r_sv[j];
                r_sr[j+1]   <= take ? (r_sr[j] >> 1) + BITV : r_sr[j] >> 1;
                r_scq[j+1]  <= r_scq[j];
                r_sneg[j+1] <= r_sneg[j];
            end
        end
    end

    // start vector; turn an obtuse angle by a quarter turn
    logic signed [AW-1:0] r_cx [0:NC];
    logic signed [AW-1:0] r_cy [0:NC];
    logic signed [AW-1:0] r_cz [0:NC];
    logic [AW-1:0]        sin_w, cos_w;

    assign sin_w = AW'(r_sr[NS]);
    assign cos_w = AW'(r_scq[NS]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cx[0] <= r_sneg[NS] ? sin_w : cos_w;
            r_cy[0] <= r_sneg[NS] ? cos_w : sin_w;
            r_cz[0] <= r_sneg[NS] ? tas_pkg::HALF_PI_Q30 : '0;
        end
    end

    // CORDIC vectoring, one micro-rotation a stage
    for (genvar i = 0; i < NC; i++) begin : g_cordic
        localparam logic [AW-1:0] ATAN = AW'(tas_pkg::atan_q30(5'(i)));
        logic signed [AW-1:0] xs, ys;
        assign xs = r_cx[i] >>> i;
        assign ys = r_cy[i] >>> i;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_cy[i][AW-1]) begin
                    r_cx[i+1] <= r_cx[i] + ys;
                    r_cy[i+1] <= r_cy[i] - xs;
                    r_cz[i+1] <= r_cz[i] + ATAN;
                end else begin
                    r_cx[i+1] <= r_cx[i] - ys;
                    r_cy[i+1] <= r_cy[i] + xs;
                    r_cz[i+1] <= r_cz[i] - ATAN;
                end
            end
        end
    end

    // clamp at zero and round half up to the output fraction
    logic [AW-1:0] zpos, zrnd, zsh;
    assign zpos = r_cz[NC][AW-1] ? '0 : r_cz[NC];
    assign zrnd = zpos + RND_RAD;
    assign zsh  = zrnd >> SH;

    logic [RADW-1:0] r_rad;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad <= zsh[RADW-1:0];
        end
    end

    // degrees: two narrow partial products, then sum and round
    logic [PRW-1:0] r_ph, r_pl;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ph <= r_rad * tas_pkg::DEG_PER_RAD[2*KS-1:KS];
            r_pl <= r_rad * tas_pkg::DEG_PER_RAD[KS-1:0];
        end
    end

    logic [TW-1:0] dtot, dsh;
    assign dtot = (TW'(r_ph) << KS) + TW'(r_pl) + RND_DEG;
    assign dsh  = dtot >> QB;

    logic [DEGW-1:0] r_deg;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_deg <= dsh[DEGW-1:0];
        end
    end

    assign o_rad = r_rad;
    assign o_deg = r_deg;

endmodule

// ===== rtl/triangle_angle_solver.sv =====
// Top level of the triangle angle solver: stream ports, validity check, sums and output beat.
//
// Takes one triangle (three unsigned side lengths) per beat and returns one result beat per
// triangle, in order. The strict triangle inequality is checked first; tuser carries the
// verdict, and a failed triangle returns all angles and sums as zero. Each angle comes from
// the law of cosines: a 30-stage restoring divider forms the Q30 cosine, a 31-stage square
// root forms the sine and a 30-stage CORDIC turns the pair into the angle, which is rounded to
// FRAC_BITS fraction bits and scaled to degrees. Three such lanes run side by side. The
// pipeline takes a new triangle in every cycle unless the result side stalls; its depth is
// set by the divider, square root and CORDIC step counts. A stall on the result side holds
// the whole pipeline, so nothing is lost or repeated, and s_tready stays high while the
// output register is empty or being emptied. Sums saturate to their field widths.
module triangle_angle_solver #(
    parameter int SIDE_BITS = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    // side_a, side_b, side_c (lowest bits first)
    input  logic [((3*SIDE_BITS+7)/8)*8-1:0] i_s_tdata,
    output logic o_m_tvalid,
    input  logic i_m_tready,
    // angle_a_rad, angle_b_rad, angle_c_rad, angle_a_deg, angle_b_deg, angle_c_deg,
    // sum_rad, sum_deg (lowest bits first)
    output logic [((8*FRAC_BITS+40+7)/8)*8-1:0] o_m_tdata,
    // triangle_ok
    output logic o_m_tuser
);

    localparam int RADW  = FRAC_BITS + 2;
    localparam int DEGW  = FRAC_BITS + 8;
    localparam int QB    = tas_pkg::QBITS;
    localparam int KS    = tas_pkg::KSPLIT;
    localparam int LL    = tas_pkg::LANE_LAT;
    localparam int NST   = LL + 3;
    localparam int FW    = 8 * FRAC_BITS + 40;
    localparam int OUT_W = ((FW + 7) / 8) * 8;
    localparam int PRW   = RADW + KS;
    localparam int TW    = RADW + 2 * KS + 1;
    localparam int SW    = RADW + 2;

    localparam logic [RADW-1:0] RMAX    = '1;
    localparam logic [DEGW-1:0] DMAX    = '1;
    localparam logic [TW-1:0]   RND_DEG = TW'(1) << (QB - 1);

    // Advance the whole pipeline unless a finished beat is waiting to be taken.
    logic en;
    assign en         = !o_m_tvalid || i_m_tready;
    assign o_s_tready = en;

    // Stage 0: capture the sides and test the strict triangle inequality.
    logic [SIDE_BITS-1:0] side_a, side_b, side_c;
    logic [SIDE_BITS:0]   sab, sac, sbc;
    logic                 tri_ok;

    assign side_a = i_s_tdata[SIDE_BITS-1:0];
    assign side_b = i_s_tdata[2*SIDE_BITS-1:SIDE_BITS];
    assign side_c = i_s_tdata[3*SIDE_BITS-1:2*SIDE_BITS];
    assign sab    = {1'b0, side_a} + {1'b0, side_b};
    assign sac    = {1'b0, side_a} + {1'b0, side_c};
    assign sbc    = {1'b0, side_b} + {1'b0, side_c};
    assign tri_ok = (sab > {1'b0, side_c}) && (sac > {1'b0, side_b}) && (sbc > {1'b0, side_a});

    logic [SIDE_BITS-1:0] r_a, r_b, r_c;
    logic [NST:0]         r_vld;
    logic [NST:0]         r_ok;

    // Valid bits are control state: clear them on reset, shift them with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NST-1:0], i_s_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a  <= side_a;
            r_b  <= side_b;
            r_c  <= side_c;
            r_ok <= {r_ok[NST-1:0], tri_ok};
        end
    end

    // Three angle lanes; each angle sits opposite its own side.
    logic [RADW-1:0] rad_a, rad_b, rad_c;
    logic [DEGW-1:0] deg_a, deg_b, deg_c;

    tas_angle #(.SIDE_BITS(SIDE_BITS), .FRAC_BITS(FRAC_BITS)) u_ang_a (
        .i_clk(i_clk), .i_en(en), .i_opp(r_a), .i_s1(r_b), .i_s2(r_c),
        .o_rad(rad_a), .o_deg(deg_a)
    );
    tas_angle #(.SIDE_BITS(SIDE_BITS), .FRAC_BITS(FRAC_BITS)) u_ang_b (
        .i_clk(i_clk), .i_en(en), .i_opp(r_b), .i_s1(r_a), .i_s2(r_c),
        .o_rad(rad_b), .o_deg(deg_b)
    );
    tas_angle #(.SIDE_BITS(SIDE_BITS), .FRAC_BITS(FRAC_BITS)) u_ang_c (
        .i_clk(i_clk), .i_en(en), .i_opp(r_c), .i_s1(r_a), .i_s2(r_b),
        .o_rad(rad_c), .o_deg(deg_c)
    );

    // Radian sum, saturated; hold the lane radians beside it.
    logic [SW-1:0] rsum;
    assign rsum = SW'(rad_a) + SW'(rad_b) + SW'(rad_c);

    logic [RADW-1:0] r_sr1, r_sr2;
    logic [RADW-1:0] r_ra1, r_rb1, r_rc1, r_ra2, r_rb2, r_rc2;
    logic [PRW-1:0]  r_sph, r_spl;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sr1 <= (rsum > SW'(RMAX)) ? RMAX : rsum[RADW-1:0];
            r_ra1 <= rad_a;
            r_rb1 <= rad_b;
            r_rc1 <= rad_c;
            // degree partial products of the sum
            r_sph <= r_sr1 * tas_pkg::DEG_PER_RAD[2*KS-1:KS];
            r_spl <= r_sr1 * tas_pkg::DEG_PER_RAD[KS-1:0];
            r_sr2 <= r_sr1;
            r_ra2 <= r_ra1;
            r_rb2 <= r_rb1;
            r_rc2 <= r_rc1;
        end
    end

    logic [TW-1:0] dtot, dsh;
    assign dtot = (TW'(r_sph) << KS) + TW'(r_spl) + RND_DEG;
    assign dsh  = dtot >> QB;

    // Output register: the beat that waits for the downstream side.
    logic [RADW-1:0] r_ora, r_orb, r_orc, r_osr;
    logic [DEGW-1:0] r_oda, r_odb, r_odc, r_osd;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ora <= r_ra2;
            r_orb <= r_rb2;
            r_orc <= r_rc2;
            r_oda <= deg_a;
            r_odb <= deg_b;
            r_odc <= deg_c;
            r_osr <= r_sr2;
            r_osd <= (dsh > TW'(DMAX)) ? DMAX : dsh[DEGW-1:0];
        end
    end

    // Drop every angle of a failed triangle to zero.
    logic [FW-1:0] fields;
    assign fields = r_ok[NST] ? {r_osd, r_osr, r_odc, r_odb, r_oda, r_orc, r_orb, r_ora} : '0;

    assign o_m_tvalid = r_vld[NST];
    assign o_m_tdata  = OUT_W'(fields);
    assign o_m_tuser  = r_ok[NST];

endmodule

// ===== rtl/tas_checker.sv =====
// Port-level checker for the triangle angle solver, bound to its top level.
module tas_checker #(
    parameter int SIDE_BITS = 16,
    parameter int FRAC_BITS = 16
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_s_tvalid,
    input logic o_s_tready,
    input logic [((3*SIDE_BITS+7)/8)*8-1:0] i_s_tdata,
    input logic o_m_tvalid,
    input logic i_m_tready,
    input logic [((8*FRAC_BITS+40+7)/8)*8-1:0] o_m_tdata,
    input logic o_m_tuser
);

    localparam int RADW = FRAC_BITS + 2;
    localparam int SRLO = 3 * RADW + 3 * (FRAC_BITS + 8);

    // a failed triangle carries no angle
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata == '0)
        else $error("failed triangle with non-zero angles");

    // an empty output register never blocks the input side
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled while output empty");

    // a stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("stalled result beat changed");

    // the saturated radian sum never falls below the first angle
    a_sum_ge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |->
            o_m_tdata[SRLO+RADW-1:SRLO] >= o_m_tdata[RADW-1:0])
        else $error("radian sum below first angle");

    // reset empties the pipeline
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("result beat after reset");

endmodule

bind triangle_angle_solver tas_checker #(
    .SIDE_BITS(SIDE_BITS),
    .FRAC_BITS(FRAC_BITS)
) u_tas_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .i_s_tvalid(i_s_tvalid),
    .o_s_tready(o_s_tready),
    .i_s_tdata(i_s_tdata),
    .o_m_tvalid(o_m_tvalid),
    .i_m_tready(i_m_tready),
    .o_m_tdata(o_m_tdata),
    .o_m_tuser(o_m_tuser)
);
